/* rtl/hall_tachometer_speed_macros.svh */
// ----------------------------------------------------------------------------
// Hall tachometer assertion macros
// Property shapes for the tachometer checker, clocked on clock and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HALL_TACHOMETER_SPEED_MACROS_SVH
`define HALL_TACHOMETER_SPEED_MACROS_SVH

// same-cycle implication
`define HTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/hts_pkg.sv */
// ----------------------------------------------------------------------------
// Hall tachometer package
// Types, codes and constants shared by the tachometer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hts_pkg;

   localparam int TIMER_WIDTH         = 16;
   localparam int SPEED_WIDTH         = 16;
   localparam int QUARTER_WIDTH       = TIMER_WIDTH - 2;
   localparam int EDGE_COUNT_WIDTH    = 3;
   localparam int COUNTER_WIDTH       = 8;
   localparam int HISTORY_DEPTH       = 4;
   localparam int HISTORY_INDEX_WIDTH = $clog2(HISTORY_DEPTH);
   localparam int HISTORY_SUM_WIDTH   = SPEED_WIDTH + HISTORY_INDEX_WIDTH;
   localparam int DIV_STEPS           = SPEED_WIDTH;
   localparam int DIV_COUNT_WIDTH     = $clog2(DIV_STEPS);
   localparam int KIND_WIDTH          = 2;
   localparam int REQ_TDATA_WIDTH     = 24;
   localparam int RSP_TDATA_WIDTH     = 16;
   localparam int CSR_ADDR_WIDTH      = 5;
   localparam int CSR_DATA_WIDTH      = 32;
   localparam int REG_INDEX_WIDTH     = 3;

   localparam logic [15:0] MIN_PERIOD_RESET     = 16'd200;
   localparam logic [7:0]  EMPTY_LIMIT_RESET    = 8'd20;
   localparam logic [2:0]  EDGES_PER_REV_RESET  = 3'd6;
   localparam logic [7:0]  OVERFLOW_LIMIT_RESET = 8'd1;
   localparam logic [15:0] RATE_NUMERATOR_RESET = 16'(125000 / 4);
   localparam logic        AVERAGE_ENABLE_RESET = 1'b0;

   localparam logic [SPEED_WIDTH-1:0]   SPEED_SATURATED = '1;
   localparam logic [COUNTER_WIDTH-1:0] OVERFLOW_MAX    = '1;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_PIN      = 2'd0,
      KIND_OVERFLOW = 2'd1,
      KIND_CALC     = 2'd2
   } kind_type;

   typedef enum logic [REG_INDEX_WIDTH-1:0] {
      REG_MIN_PERIOD     = 3'd0,
      REG_EMPTY_LIMIT    = 3'd1,
      REG_EDGES_PER_REV  = 3'd2,
      REG_OVERFLOW_LIMIT = 3'd3,
      REG_RATE_NUMERATOR = 3'd4,
      REG_AVERAGE_ENABLE = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_APPLY,
      ST_AVERAGE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [15:0] min_period;
      logic [7:0]  empty_limit;
      logic [2:0]  edges_per_rev;
      logic [7:0]  overflow_limit;
      logic [15:0] rate_numerator;
      logic        average_enable;
   } cfg_type;

   typedef struct packed {
      logic                   done;
      logic [SPEED_WIDTH-1:0] quotient;
   } div_status_type;

endpackage

`default_nettype wire

/* rtl/hts_csr.sv */
// ----------------------------------------------------------------------------
// Hall tachometer configuration registers
// APB-style register file holding the six tachometer settings.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [hts_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [hts_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [hts_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                    csr_pready,
   output hts_pkg::cfg_type                        cfg
);

   hts_pkg::cfg_type       cfg_ff;
   hts_pkg::cfg_type       cfg_in;
   hts_pkg::reg_index_type reg_index;
   logic                   write_fire;

   assign reg_index  = hts_pkg::reg_index_type'(csr_paddr[hts_pkg::CSR_ADDR_WIDTH-1:2]);
   assign write_fire = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_fire) begin
         unique case (reg_index)
            hts_pkg::REG_MIN_PERIOD:     cfg_in.min_period     = csr_pwdata[15:0];
            hts_pkg::REG_EMPTY_LIMIT:    cfg_in.empty_limit    = csr_pwdata[7:0];
            hts_pkg::REG_EDGES_PER_REV:  cfg_in.edges_per_rev  = csr_pwdata[2:0];
            hts_pkg::REG_OVERFLOW_LIMIT: cfg_in.overflow_limit = csr_pwdata[7:0];
            hts_pkg::REG_RATE_NUMERATOR: cfg_in.rate_numerator = csr_pwdata[15:0];
            hts_pkg::REG_AVERAGE_ENABLE: cfg_in.average_enable = csr_pwdata[0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         hts_pkg::REG_MIN_PERIOD:     csr_prdata = 32'(cfg_ff.min_period);
         hts_pkg::REG_EMPTY_LIMIT:    csr_prdata = 32'(cfg_ff.empty_limit);
         hts_pkg::REG_EDGES_PER_REV:  csr_prdata = 32'(cfg_ff.edges_per_rev);
         hts_pkg::REG_OVERFLOW_LIMIT: csr_prdata = 32'(cfg_ff.overflow_limit);
         hts_pkg::REG_RATE_NUMERATOR: csr_prdata = 32'(cfg_ff.rate_numerator);
         hts_pkg::REG_AVERAGE_ENABLE: csr_prdata = 32'(cfg_ff.average_enable);
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_period     <= hts_pkg::MIN_PERIOD_RESET;
         cfg_ff.empty_limit    <= hts_pkg::EMPTY_LIMIT_RESET;
         cfg_ff.edges_per_rev  <= hts_pkg::EDGES_PER_REV_RESET;
         cfg_ff.overflow_limit <= hts_pkg::OVERFLOW_LIMIT_RESET;
         cfg_ff.rate_numerator <= hts_pkg::RATE_NUMERATOR_RESET;
         cfg_ff.average_enable <= hts_pkg::AVERAGE_ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/hts_div.sv */
// ----------------------------------------------------------------------------
// Hall tachometer divider
// Restoring divider, one quotient bit per cycle, pulses done with the result.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [hts_pkg::SPEED_WIDTH-1:0]     dividend,
   input  wire logic [hts_pkg::QUARTER_WIDTH-1:0]   divisor,
   output hts_pkg::div_status_type                  status
);

   logic                                  busy_ff;
   logic                                  busy_in;
   logic                                  done_ff;
   logic                                  done_in;
   logic [hts_pkg::DIV_COUNT_WIDTH-1:0]   count_ff;
   logic [hts_pkg::DIV_COUNT_WIDTH-1:0]   count_in;
   logic [hts_pkg::QUARTER_WIDTH-1:0]     rem_ff;
   logic [hts_pkg::QUARTER_WIDTH-1:0]     rem_in;
   logic [hts_pkg::SPEED_WIDTH-1:0]       quot_ff;
   logic [hts_pkg::SPEED_WIDTH-1:0]       quot_in;
   logic [hts_pkg::QUARTER_WIDTH-1:0]     divisor_ff;
   logic [hts_pkg::QUARTER_WIDTH-1:0]     divisor_in;
   logic [hts_pkg::QUARTER_WIDTH:0]       rem_shift;
   logic [hts_pkg::QUARTER_WIDTH+1:0]     diff;

   assign rem_shift = {rem_ff, quot_ff[hts_pkg::SPEED_WIDTH-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, divisor_ff};

   assign status.done     = done_ff;
   assign status.quotient = quot_ff;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         quot_in    = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         if (!diff[hts_pkg::QUARTER_WIDTH+1]) begin
            rem_in  = diff[hts_pkg::QUARTER_WIDTH-1:0];
            quot_in = {quot_ff[hts_pkg::SPEED_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[hts_pkg::QUARTER_WIDTH-1:0];
            quot_in = {quot_ff[hts_pkg::SPEED_WIDTH-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == hts_pkg::DIV_COUNT_WIDTH'(hts_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

endmodule

`default_nettype wire

/* rtl/hall_tachometer_speed.sv */
// ----------------------------------------------------------------------------
// Hall tachometer speed
// Period-measuring tachometer for one hall sensor channel.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. Pin samples, overflow ticks
// and calculation ticks that leave the speed alone or clear it go from
// acceptance straight to the emit state. A dividing calculation tick runs the
// 16-step restoring divider, then the apply state, the average state when
// averaging is enabled, and the emit state. A calculation tick whose quartered
// period is zero skips the divider and saturates the speed via the apply state.
// The input is not ready while a transaction is in progress; a finished
// result waits in the output register while the next transaction is taken.
`default_nettype none

module hall_tachometer_speed (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [0] pin_level, [16:1] timer_count, [23:17] zero
   input  wire logic [hts_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   // [1:0] kind
   input  wire logic [hts_pkg::KIND_WIDTH-1:0]       req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [15:0] speed
   output logic      [hts_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   // [0] speed_updated
   output logic      [0:0]                           rsp_tuser,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [hts_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire logic [hts_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic      [hts_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                      csr_pready
);

   localparam int TW = hts_pkg::TIMER_WIDTH;
   localparam int SW = hts_pkg::SPEED_WIDTH;
   localparam int CW = hts_pkg::COUNTER_WIDTH;
   localparam int EW = hts_pkg::EDGE_COUNT_WIDTH;
   localparam int HW = hts_pkg::HISTORY_INDEX_WIDTH;

   hts_pkg::cfg_type        cfg;
   hts_pkg::div_status_type div_status;
   hts_pkg::state_type      state_ff;
   hts_pkg::state_type      state_in;
   hts_pkg::kind_type       req_kind;

   logic                    last_pin_ff, last_pin_in;
   logic [TW-1:0]           last_edge_time_ff, last_edge_time_in;
   logic [EW-1:0]           edge_count_ff, edge_count_in;
   logic [TW-1:0]           window_open_ff, window_open_in;
   logic [TW-1:0]           window_start_ff, window_start_in;
   logic [TW-1:0]           window_end_ff, window_end_in;
   logic [CW-1:0]           overflow_count_ff, overflow_count_in;
   logic [CW-1:0]           empty_count_ff, empty_count_in;
   logic [SW-1:0]           history_ff [hts_pkg::HISTORY_DEPTH];
   logic [SW-1:0]           history_in [hts_pkg::HISTORY_DEPTH];
   logic [HW-1:0]           history_index_ff, history_index_in;
   logic [SW-1:0]           speed_value_ff, speed_value_in;
   logic                    updated_ff, updated_in;
   logic [SW-1:0]           rate_ff, rate_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]           rsp_speed_ff, rsp_speed_in;
   logic                    rsp_updated_ff, rsp_updated_in;

   logic                    req_fire;
   logic                    req_pin;
   logic [TW-1:0]           req_timer;
   logic [EW-1:0]           edge_next;
   logic [TW-1:0]           period;
   logic [hts_pkg::QUARTER_WIDTH-1:0] quarter;
   logic [hts_pkg::HISTORY_SUM_WIDTH-1:0] history_sum;
   logic                    div_start;

   assign req_tready = (state_ff == hts_pkg::ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign req_kind   = hts_pkg::kind_type'(req_tuser);
   assign req_pin    = req_tdata[0];
   assign req_timer  = req_tdata[TW:1];
   assign edge_next  = edge_count_ff + 1'b1;
   assign period     = window_end_ff - window_start_ff;
   assign quarter    = period[TW-1:2];

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_speed_ff;
   assign rsp_tuser[0] = rsp_updated_ff;

   hts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cfg.rate_numerator),
      .divisor  (quarter),
      .status   (div_status)
   );

   always_comb begin
      history_sum = '0;
      for (int i = 0; i < hts_pkg::HISTORY_DEPTH; i++) begin
         history_sum = history_sum + hts_pkg::HISTORY_SUM_WIDTH'(history_ff[i]);
      end
   end

   always_comb begin
      state_in          = state_ff;
      last_pin_in       = last_pin_ff;
      last_edge_time_in = last_edge_time_ff;
      edge_count_in     = edge_count_ff;
      window_open_in    = window_open_ff;
      window_start_in   = window_start_ff;
      window_end_in     = window_end_ff;
      overflow_count_in = overflow_count_ff;
      empty_count_in    = empty_count_ff;
      history_in        = history_ff;
      history_index_in  = history_index_ff;
      speed_value_in    = speed_value_ff;
      updated_in        = updated_ff;
      rate_in           = rate_ff;
      rsp_valid_in      = rsp_valid_ff & ~rsp_tready;
      rsp_speed_in      = rsp_speed_ff;
      rsp_updated_in    = rsp_updated_ff;
      div_start         = 1'b0;

      unique case (state_ff)
         hts_pkg::ST_IDLE: begin
            if (req_fire) begin
               updated_in = 1'b0;
               state_in   = hts_pkg::ST_EMIT;
               case (req_kind)
                  hts_pkg::KIND_PIN: begin
                     if (req_pin && !last_pin_ff) begin
                        if (last_edge_time_ff != '0) begin
                           if (edge_next == cfg.edges_per_rev) begin
                              edge_count_in     = '0;
                              window_end_in     = req_timer;
                              window_start_in   = window_open_ff;
                              window_open_in    = req_timer;
                              overflow_count_in = '0;
                           end else begin
                              edge_count_in = edge_next;
                           end
                        end
                        last_edge_time_in = req_timer;
                     end
                     last_pin_in = req_pin;
                  end
                  hts_pkg::KIND_OVERFLOW: begin
                     if (overflow_count_ff != hts_pkg::OVERFLOW_MAX) begin
                        overflow_count_in = overflow_count_ff + 1'b1;
                     end
                  end
                  hts_pkg::KIND_CALC: begin
                     if (overflow_count_ff > cfg.overflow_limit) begin
                        speed_value_in    = '0;
                        window_start_in   = '0;
                        window_end_in     = '0;
                        overflow_count_in = '0;
                        updated_in        = 1'b1;
                     end else if (window_start_ff != '0 && window_end_ff != '0) begin
                        if (period > cfg.min_period) begin
                           window_start_in = '0;
                           window_end_in   = '0;
                           empty_count_in  = '0;
                           updated_in      = 1'b1;
                           if (quarter == '0) begin
                              rate_in  = hts_pkg::SPEED_SATURATED;
                              state_in = hts_pkg::ST_APPLY;
                           end else begin
                              div_start = 1'b1;
                              state_in  = hts_pkg::ST_DIVIDE;
                           end
                        end
                     end else begin
                        empty_count_in = empty_count_ff + 1'b1;
                        if (empty_count_ff > cfg.empty_limit) begin
                           speed_value_in = '0;
                           empty_count_in = '0;
                           updated_in     = 1'b1;
                        end
                     end
                  end
                  default: begin
                     state_in = hts_pkg::ST_EMIT;
                  end
               endcase
            end
         end
         hts_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               rate_in  = div_status.quotient;
               state_in = hts_pkg::ST_APPLY;
            end
         end
         hts_pkg::ST_APPLY: begin
            if (cfg.average_enable) begin
               history_in[history_index_ff] = rate_ff;
               history_index_in             = history_index_ff + 1'b1;
               state_in                     = hts_pkg::ST_AVERAGE;
            end else begin
               speed_value_in = rate_ff;
               state_in       = hts_pkg::ST_EMIT;
            end
         end
         hts_pkg::ST_AVERAGE: begin
            speed_value_in = history_sum[hts_pkg::HISTORY_SUM_WIDTH-1:HW];
            state_in       = hts_pkg::ST_EMIT;
         end
         hts_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_speed_in   = speed_value_ff;
               rsp_updated_in = updated_ff;
               state_in       = hts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= hts_pkg::ST_IDLE;
         last_pin_ff       <= 1'b0;
         last_edge_time_ff <= '0;
         edge_count_ff     <= '0;
         window_open_ff    <= '0;
         window_start_ff   <= '0;
         window_end_ff     <= '0;
         overflow_count_ff <= '0;
         empty_count_ff    <= '0;
         for (int i = 0; i < hts_pkg::HISTORY_DEPTH; i++) begin
            history_ff[i] <= '0;
         end
         history_index_ff  <= '0;
         speed_value_ff    <= '0;
         updated_ff        <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         last_pin_ff       <= last_pin_in;
         last_edge_time_ff <= last_edge_time_in;
         edge_count_ff     <= edge_count_in;
         window_open_ff    <= window_open_in;
         window_start_ff   <= window_start_in;
         window_end_ff     <= window_end_in;
         overflow_count_ff <= overflow_count_in;
         empty_count_ff    <= empty_count_in;
         history_ff        <= history_in;
         history_index_ff  <= history_index_in;
         speed_value_ff    <= speed_value_in;
         updated_ff        <= updated_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      rate_ff        <= rate_in;
      rsp_speed_ff   <= rsp_speed_in;
      rsp_updated_ff <= rsp_updated_in;
   end

endmodule

`default_nettype wire

/* rtl/hall_tachometer_speed_checker.sv */
// ----------------------------------------------------------------------------
// Hall tachometer checker
// Port-level assertions for the tachometer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hall_tachometer_speed_macros.svh"

module hall_tachometer_speed_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_tvalid,
   input wire logic                                 req_tready,
   input wire logic [hts_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   input wire logic [hts_pkg::KIND_WIDTH-1:0]       req_tuser,
   input wire logic                                 rsp_tvalid,
   input wire logic                                 rsp_tready,
   input wire logic [hts_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   input wire logic [0:0]                           rsp_tuser
);

   logic                                  req_fire;
   logic                                  rsp_fire;
   logic [1:0]                            pending_ff;
   logic [1:0]                            pending_in;
   logic [hts_pkg::RSP_TDATA_WIDTH-1:0]   last_speed_ff;
   logic                                  req_seen;

   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = rsp_tvalid & rsp_tready;
   assign pending_in = pending_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
   assign req_seen   = (req_tdata != '0) || (req_tuser != '0) || 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         last_speed_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         if (rsp_fire) begin
            last_speed_ff <= rsp_tdata;
         end
      end
   end

   // hold a stalled result
   `HTS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // one transaction at a time
   `HTS_ASSERT_NEXT(a_one_at_a_time, req_fire && req_seen, !req_tready, "input ready right after acceptance")

   // speed changes only on updated results
   `HTS_ASSERT_NOW(a_speed_steady, rsp_tvalid && !rsp_tuser[0], rsp_tdata == last_speed_ff, "speed changed without update")

   // no result without a transaction, at most two in flight
   `HTS_ASSERT_NOW(a_pending, rsp_tvalid || pending_ff != 2'd0, pending_ff != 2'd0 && pending_ff <= 2'd2, "result count mismatch")

endmodule

bind hall_tachometer_speed hall_tachometer_speed_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

/* tb/hall_tachometer_speed_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hall tachometer speed testbench
// Sends pin samples, timer overflow ticks and calculation ticks through the
// request stream. Each transaction is checked against an in-bench model of the
// edge counting, revolution window, divider, averaging and zeroing rules.
// A directed table runs first, then random phases under several register
// settings and handshake idling patterns. Register writes are read back.
// ----------------------------------------------------------------------------
module hall_tachometer_speed_tb;

   localparam logic [hts_pkg::KIND_WIDTH-1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT      = 1000000;
   localparam int SETTLE_CYCLES    = 25;
   localparam int ITEMS_PER_PHASE  = 90;
   localparam int PHASE_COUNT      = 8;
   localparam int DIRECTED_ROWS    = 25;
   localparam int OVERFLOW_BURST   = 300;

   typedef struct {
      logic [15:0] speed;
      logic        updated;
   } speed_result_type;

   typedef struct {
      logic [hts_pkg::KIND_WIDTH-1:0] kind;
      logic                           pin;
      logic [15:0]                    stamp;
      logic                           typed;
      logic [15:0]                    speed;
      logic                           updated;
   } stim_row_type;

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [hts_pkg::REQ_TDATA_WIDTH-1:0] req_tdata;
   logic [hts_pkg::KIND_WIDTH-1:0]      req_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [hts_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic [0:0]                          rsp_tuser;
   logic                                csr_psel;
   logic                                csr_penable;
   logic                                csr_pwrite;
   logic [hts_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr;
   logic [hts_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata;
   logic [hts_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata;
   logic                                csr_pready;

   speed_result_type expected_speeds [$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned stall_pct       = 0;

   // tachometer model state
   hts_pkg::cfg_type cfg;
   logic        prev_pin;
   logic [15:0] last_capture;
   logic [2:0]  edges_seen;
   logic [15:0] open_stamp;
   logic [15:0] win_begin;
   logic [15:0] win_end;
   logic [7:0]  overflow_ticks;
   logic [7:0]  empty_ticks;
   logic [15:0] history [hts_pkg::HISTORY_DEPTH];
   logic [1:0]  history_ptr;
   logic [15:0] speed_now;

   // random sensor waveform state
   logic [15:0] run_timer;
   logic        drive_level;
   int unsigned tight_left;

   hts_pkg::cfg_type setups [PHASE_COUNT];

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{KIND_UNUSED,            1'b0, 16'd0,     1'b1, 16'd0, 1'b0},
      '{hts_pkg::KIND_CALC,     1'b0, 16'd0,     1'b1, 16'd0, 1'b0},
      '{hts_pkg::KIND_PIN,      1'b1, 16'hFFFF,  1'b1, 16'd0, 1'b0},
      '{hts_pkg::KIND_PIN,      1'b0, 16'd0,     1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_PIN,      1'b1, 16'd0,     1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_PIN,      1'b0, 16'd0,     1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_PIN,      1'b1, 16'd1000,  1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_PIN,      1'b0, 16'd2000,  1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_PIN,      1'b1, 16'd3000,  1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_PIN,      1'b0, 16'd5000,  1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_PIN,      1'b1, 16'd7000,  1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_CALC,     1'b0, 16'd0,     1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_PIN,      1'b0, 16'd7050,  1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_PIN,      1'b1, 16'd7100,  1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_CALC,     1'b0, 16'd0,     1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_OVERFLOW, 1'b0, 16'd0,     1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_OVERFLOW, 1'b1, 16'hFFFF,  1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_CALC,     1'b0, 16'd0,     1'b1, 16'd0, 1'b1},
      '{hts_pkg::KIND_PIN,      1'b0, 16'd60000, 1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_PIN,      1'b1, 16'd65000, 1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_PIN,      1'b0, 16'd65535, 1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_PIN,      1'b1, 16'd1000,  1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_CALC,     1'b0, 16'd0,     1'b0, 16'd0, 1'b0},
      '{KIND_UNUSED,            1'b1, 16'hFFFF,  1'b0, 16'd0, 1'b0},
      '{hts_pkg::KIND_CALC,     1'b1, 16'hFFFF,  1'b0, 16'd0, 1'b0}
   };

   hall_tachometer_speed DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      mismatch_count++;
   endtask

   task automatic reset_model();
      cfg.min_period     = hts_pkg::MIN_PERIOD_RESET;
      cfg.empty_limit    = hts_pkg::EMPTY_LIMIT_RESET;
      cfg.edges_per_rev  = hts_pkg::EDGES_PER_REV_RESET;
      cfg.overflow_limit = hts_pkg::OVERFLOW_LIMIT_RESET;
      cfg.rate_numerator = hts_pkg::RATE_NUMERATOR_RESET;
      cfg.average_enable = hts_pkg::AVERAGE_ENABLE_RESET;
      prev_pin       = 1'b0;
      last_capture   = '0;
      edges_seen     = '0;
      open_stamp     = '0;
      win_begin      = '0;
      win_end        = '0;
      overflow_ticks = '0;
      empty_ticks    = '0;
      for (int i = 0; i < hts_pkg::HISTORY_DEPTH; i++) history[i] = '0;
      history_ptr    = '0;
      speed_now      = '0;
   endtask

   function automatic speed_result_type tachometer_step(
                                   input logic [hts_pkg::KIND_WIDTH-1:0] kind,
                                   input logic pin,
                                   input logic [15:0] stamp);
      speed_result_type r;
      logic [15:0] period;
      logic [15:0] quarter;
      logic [15:0] rate;
      logic [17:0] sum;
      logic [7:0]  prior;
      r.updated = 1'b0;
      case (kind)
         hts_pkg::KIND_PIN: begin
            if (pin && !prev_pin) begin
               if (last_capture != 16'd0) begin
                  edges_seen = edges_seen + 3'd1;
                  if (edges_seen == cfg.edges_per_rev) begin
                     edges_seen     = '0;
                     win_end        = stamp;
                     win_begin      = open_stamp;
                     open_stamp     = stamp;
                     overflow_ticks = '0;
                  end
               end
               last_capture = stamp;
            end
            prev_pin = pin;
         end
         hts_pkg::KIND_OVERFLOW: begin
            if (overflow_ticks != hts_pkg::OVERFLOW_MAX)
               overflow_ticks = overflow_ticks + 8'd1;
         end
         hts_pkg::KIND_CALC: begin
            if (overflow_ticks > cfg.overflow_limit) begin
               speed_now      = '0;
               win_begin      = '0;
               win_end        = '0;
               overflow_ticks = '0;
               r.updated      = 1'b1;
            end else if (win_begin != 16'd0 && win_end != 16'd0) begin
               period = win_end - win_begin;
               if (period > cfg.min_period) begin
                  quarter = period >> 2;
                  rate = (quarter == 16'd0) ? hts_pkg::SPEED_SATURATED
                                            : cfg.rate_numerator / quarter;
                  if (cfg.average_enable) begin
                     history[history_ptr] = rate;
                     history_ptr = history_ptr + 2'd1;
                     sum = history[0] + history[1] + history[2] + history[3];
                     speed_now = sum[17:2];
                  end else begin
                     speed_now = rate;
                  end
                  win_begin   = '0;
                  win_end     = '0;
                  empty_ticks = '0;
                  r.updated   = 1'b1;
               end
            end else begin
               prior       = empty_ticks;
               empty_ticks = empty_ticks + 8'd1;
               if (prior > cfg.empty_limit) begin
                  speed_now   = '0;
                  empty_ticks = '0;
                  r.updated   = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.speed = speed_now;
      return r;
   endfunction

   task automatic csr_write(input hts_pkg::reg_index_type idx, input logic [31:0] value);
      logic [31:0] field;
      case (idx)
         hts_pkg::REG_MIN_PERIOD: begin
            field = value & 32'hFFFF;
            cfg.min_period = field[15:0];
         end
         hts_pkg::REG_EMPTY_LIMIT: begin
            field = value & 32'hFF;
            cfg.empty_limit = field[7:0];
         end
         hts_pkg::REG_EDGES_PER_REV: begin
            field = value & 32'h7;
            cfg.edges_per_rev = field[2:0];
         end
         hts_pkg::REG_OVERFLOW_LIMIT: begin
            field = value & 32'hFF;
            cfg.overflow_limit = field[7:0];
         end
         hts_pkg::REG_RATE_NUMERATOR: begin
            field = value & 32'hFFFF;
            cfg.rate_numerator = field[15:0];
         end
         default: begin
            field = value & 32'h1;
            cfg.average_enable = field[0];
         end
      endcase
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== field) report_mismatch("register readback", csr_prdata, field);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_setup(input hts_pkg::cfg_type c);
      csr_write(hts_pkg::REG_MIN_PERIOD,     32'(c.min_period));
      csr_write(hts_pkg::REG_EMPTY_LIMIT,    32'(c.empty_limit));
      csr_write(hts_pkg::REG_EDGES_PER_REV,  32'(c.edges_per_rev));
      csr_write(hts_pkg::REG_OVERFLOW_LIMIT, 32'(c.overflow_limit));
      csr_write(hts_pkg::REG_RATE_NUMERATOR, 32'(c.rate_numerator));
      csr_write(hts_pkg::REG_AVERAGE_ENABLE, 32'(c.average_enable));
   endtask

   task automatic send_item(input logic [hts_pkg::KIND_WIDTH-1:0] kind, input logic pin,
                            input logic [15:0] stamp, input logic typed,
                            input logic [15:0] typed_speed, input logic typed_updated);
      speed_result_type want;
      @(negedge clock);
      while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, stamp, pin};
      do @(posedge clock); while (!req_tready);
      want = tachometer_step(kind, pin, stamp);
      if (typed) begin
         want.speed   = typed_speed;
         want.updated = typed_updated;
      end
      expected_speeds.push_back(want);
   endtask

   task automatic send_random_item();
      logic [hts_pkg::KIND_WIDTH-1:0] kind;
      logic [15:0]                    stamp;
      int unsigned                    pick;
      int unsigned                    shape;
      pick  = $urandom_range(0, 99);
      stamp = 16'($urandom);
      if (pick < 68) begin
         kind = hts_pkg::KIND_PIN;
         drive_level = ($urandom_range(0, 9) == 0) ? 1'($urandom) : ~drive_level;
         if (tight_left != 0) begin
            run_timer  = run_timer + 16'($urandom_range(0, 9) == 0);
            tight_left--;
         end else begin
            shape = $urandom_range(0, 99);
            if (shape < 3) begin
               tight_left = 20;
            end else if (shape < 6) begin
               run_timer = '0;
            end else if (shape < 16) begin
               run_timer = run_timer + 16'($urandom);
            end else begin
               run_timer = run_timer + 16'($urandom_range(1, 1500));
            end
         end
         stamp = run_timer;
         send_item(kind, drive_level, stamp, 1'b0, 16'd0, 1'b0);
      end else begin
         if (pick < 76) kind = hts_pkg::KIND_OVERFLOW;
         else if (pick < 96) kind = hts_pkg::KIND_CALC;
         else kind = KIND_UNUSED;
         send_item(kind, 1'($urandom), stamp, 1'b0, 16'd0, 1'b0);
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_speeds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin : rsp_check
      speed_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_speeds.size() == 0) begin
            report_mismatch("unexpected speed transaction", 32'(rsp_tdata), 32'd0);
         end else begin
            want = expected_speeds.pop_front();
            if (rsp_tdata !== want.speed)
               report_mismatch("speed", 32'(rsp_tdata), 32'(want.speed));
            if (rsp_tuser[0] !== want.updated)
               report_mismatch("speed_updated", 32'(rsp_tuser), 32'(want.updated));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = hts_pkg::KIND_PIN;
      rsp_tready  = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      run_timer   = 16'd1;
      drive_level = 1'b0;
      tight_left  = 0;
      setups[0] = '{16'd200,   8'd20,  3'd6, 8'd1,   16'd31250, 1'b0};
      setups[1] = '{16'd3,     8'd0,   3'd0, 8'd0,   16'd65535, 1'b1};
      setups[2] = '{16'd65535, 8'd254, 3'd7, 8'd200, 16'd1,     1'b0};
      setups[3] = '{16'd0,     8'd255, 3'd1, 8'd255, 16'd40000, 1'b1};
      setups[4] = '{16'd100,   8'd5,   3'd2, 8'd3,   16'd12345, 1'b1};
      setups[5] = '{16'd1000,  8'd1,   3'd3, 8'd254, 16'd65535, 1'b0};
      setups[6] = '{16'd50,    8'd10,  3'd4, 8'd2,   16'd500,   1'b1};
      setups[7] = '{16'($urandom_range(3, 3000)), 8'($urandom_range(0, 254)),
                    3'($urandom_range(1, 7)), 8'($urandom_range(0, 254)),
                    16'($urandom_range(1, 65535)), 1'($urandom)};
      reset_model();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one edge per window keeps the directed table short
      csr_write(hts_pkg::REG_EDGES_PER_REV, 32'd1);
      foreach (directed_rows[i])
         send_item(directed_rows[i].kind, directed_rows[i].pin, directed_rows[i].stamp,
                   directed_rows[i].typed, directed_rows[i].speed, directed_rows[i].updated);
      settle();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p % 4)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 48; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 48; end
            default: begin sender_idle_pct = 15; stall_pct = 15; end
         endcase
         apply_setup(setups[p]);
         // saturate the overflow counter, then let a calculation see it
         if (setups[p].overflow_limit == 8'd254) begin
            repeat (OVERFLOW_BURST) send_item(hts_pkg::KIND_OVERFLOW, 1'($urandom),
                                              16'($urandom), 1'b0, 16'd0, 1'b0);
            send_item(hts_pkg::KIND_CALC, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0);
         end
         repeat (ITEMS_PER_PHASE) send_random_item();
         settle();
      end

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
